// File: sv/nbai_pkg.sv
// Shared types and codes for the neighbor 4x4-block availability/index block.
`default_nettype none
package nbai_pkg;

    localparam int unsigned CFG_W   = 10;
    localparam int unsigned COORD_W = 9;
    localparam int unsigned PW_W    = 3;
    localparam int unsigned IDX_W   = 18;
    localparam int unsigned TX_W    = CFG_W;
    localparam int unsigned PROD_W  = COORD_W + CFG_W;

    typedef enum logic [1:0] {
        KIND_A = 2'd0,
        KIND_B = 2'd1,
        KIND_C = 2'd2,
        KIND_D = 2'd3
    } t_kind;

    typedef struct packed {
        logic [COORD_W-1:0] block_x;
        logic [COORD_W-1:0] block_y;
        logic [PW_W-1:0]    part_width;
        logic [1:0]         neighbor_kind;
    } t_nbai_in;

    typedef struct packed {
        logic             available;
        logic [IDX_W-1:0] neighbor_index;
    } t_nbai_out;

    typedef struct packed {
        logic               ok;
        logic [TX_W-1:0]    tx;
        logic [COORD_W-1:0] ty;
    } t_nbai_tgt;

endpackage
`default_nettype wire

// File: sv/nbai_target.sv
// Neighbor target position and availability, including decode-order check for C.
`default_nettype none
module nbai_target (
    input  nbai_pkg::t_nbai_in      i_item,
    input  logic [nbai_pkg::CFG_W-1:0] i_width,
    output nbai_pkg::t_nbai_tgt     o_tgt
);
    import nbai_pkg::*;

    logic [TX_W-1:0]    x_ext;
    logic [TX_W-1:0]    tx_c;
    logic [COORD_W-1:0] y_m1;
    logic               x_nz;
    logic               y_nz;
    logic               c_in_order;

    // raster order, macroblock level first, then 8x8, then 4x4
    function automatic logic decoded_before(input logic [TX_W-1:0] tx,
                                            input logic [COORD_W-1:0] ty,
                                            input logic [TX_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
        logic res;
        res = 1'b0;
        if (ty[COORD_W-1:2] < y[COORD_W-1:2]) begin
            res = 1'b1;
        end else if (ty[COORD_W-1:2] > y[COORD_W-1:2]) begin
            res = 1'b0;
        end else if (tx[TX_W-1:2] != x[TX_W-1:2]) begin
            res = (tx[TX_W-1:2] < x[TX_W-1:2]);
        end else if (ty[COORD_W-1:1] != y[COORD_W-1:1]) begin
            res = (ty[COORD_W-1:1] < y[COORD_W-1:1]);
        end else if (tx[TX_W-1:1] != x[TX_W-1:1]) begin
            res = (tx[TX_W-1:1] < x[TX_W-1:1]);
        end else if (ty != y) begin
            res = (ty < y);
        end else begin
            res = (tx < x);
        end
        return res;
    endfunction

    assign x_ext      = TX_W'(i_item.block_x);
    assign tx_c       = x_ext + TX_W'(i_item.part_width);
    assign y_m1       = i_item.block_y - COORD_W'(1);
    assign x_nz       = (i_item.block_x != '0);
    assign y_nz       = (i_item.block_y != '0);
    assign c_in_order = decoded_before(tx_c, y_m1, x_ext, i_item.block_y);

    always_comb begin
        o_tgt = '0;
        unique case (t_kind'(i_item.neighbor_kind))
            KIND_A: begin
                o_tgt.ok = x_nz;
                o_tgt.tx = x_ext - TX_W'(1);
                o_tgt.ty = i_item.block_y;
            end
            KIND_B: begin
                o_tgt.ok = y_nz;
                o_tgt.tx = x_ext;
                o_tgt.ty = y_m1;
            end
            KIND_C: begin
                o_tgt.ok = (tx_c < i_width) && y_nz && c_in_order;
                o_tgt.tx = tx_c;
                o_tgt.ty = y_m1;
            end
            KIND_D: begin
                o_tgt.ok = x_nz && y_nz;
                o_tgt.tx = x_ext - TX_W'(1);
                o_tgt.ty = y_m1;
            end
            default: begin
                o_tgt = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/neighbor_block_availability_index_top.sv
// Top level: three-stage pipeline returning neighbor availability and raster index.
//
//  channel | dir | handshake                  | payload
//  in      | in  | i_in_valid / o_in_stall    | i_in_item  (t_nbai_in)
//  out     | out | o_out_valid / i_out_stall  | o_out_item (t_nbai_out)
//  cfg     | in  | i_cfg_wr_en                | i_cfg_wr_data (frame width, 4x4 blocks)
//
// One item per cycle while the output is not stalled; stages: target/compare, width multiply, add.
// Each stage holds while the one after it is full and stalled; bubbles close up.
// Synchronous active-low reset empties the pipeline and sets the width to 480.
`default_nettype none
module neighbor_block_availability_index_top #(
    parameter int MAX_WIDTH_BLOCKS = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  nbai_pkg::t_nbai_in            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output nbai_pkg::t_nbai_out           o_out_item,
    input  logic                          i_cfg_wr_en,
    input  logic [nbai_pkg::CFG_W-1:0]    i_cfg_wr_data
);
    import nbai_pkg::*;

    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam int W_CAP     = (MAX_WIDTH_BLOCKS > CFG_MAX) ? CFG_MAX : MAX_WIDTH_BLOCKS;
    localparam int W_RST_INT = (480 > MAX_WIDTH_BLOCKS) ? MAX_WIDTH_BLOCKS : 480;
    localparam logic [CFG_W-1:0] W_MAX = CFG_W'(W_CAP);
    localparam logic [CFG_W-1:0] W_RST = CFG_W'(W_RST_INT);

    logic [CFG_W-1:0]   r_width;
    logic [CFG_W-1:0]   n_width;

    t_nbai_tgt          n_tgt;
    logic               rdy1, rdy2, rdy3;

    logic               r_s1_v;
    t_nbai_tgt          r_s1_tgt;
    logic [CFG_W-1:0]   r_s1_w;

    logic               r_s2_v;
    logic               r_s2_ok;
    logic [TX_W-1:0]    r_s2_tx;
    logic [PROD_W-1:0]  r_s2_prod;

    logic [PROD_W-1:0]  n_sum;
    logic               r_out_v;
    t_nbai_out          r_out_item;

    // width is clamped on write
    assign n_width = (int'(i_cfg_wr_data) > MAX_WIDTH_BLOCKS) ? W_MAX : i_cfg_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= W_RST;
        end else if (i_cfg_wr_en) begin
            r_width <= n_width;
        end
    end

    nbai_target u_target (
        .i_item  (i_in_item),
        .i_width (r_width),
        .o_tgt   (n_tgt)
    );

    assign rdy3       = !r_out_v || !i_out_stall;
    assign rdy2       = !r_s2_v || rdy3;
    assign rdy1       = !r_s1_v || rdy2;
    assign o_in_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_v <= i_in_valid;
            end
            if (rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (rdy3) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    assign n_sum = PROD_W'(r_s2_tx) + r_s2_prod;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_tgt <= n_tgt;
            r_s1_w   <= r_width;
        end
        if (rdy2) begin
            r_s2_ok   <= r_s1_tgt.ok;
            r_s2_tx   <= r_s1_tgt.tx;
            r_s2_prod <= PROD_W'(r_s1_tgt.ty) * PROD_W'(r_s1_w);
        end
        if (rdy3) begin
            r_out_item.available      <= r_s2_ok;
            r_out_item.neighbor_index <= r_s2_ok ? n_sum[IDX_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

// File: sv/nbai_checker.sv
// Port-level checks for the neighbor availability block, bound to the top level.
`default_nettype none
module nbai_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_in_stall,
    input  nbai_pkg::t_nbai_out    o_out_item,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall
);
    import nbai_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled output item changed");

    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.available |-> o_out_item.neighbor_index == '0)
        else $error("unavailable neighbor with nonzero index");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || !i_out_stall |-> !o_in_stall)
        else $error("input stalled while output side is free");

endmodule

bind neighbor_block_availability_index_top nbai_checker u_nbai_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_item  (o_out_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for neighbor_block_availability_index_top: directed and random lookups.
module tb;
    import nbai_pkg::*;

    localparam int MAX_W      = 512;
    localparam int LATENCY    = 3;
    localparam int RAND_ITEMS = 1830;
    localparam int N_PHASES   = 9;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_nbai_in            i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    t_nbai_out           o_out_item;
    logic                i_cfg_wr_en;
    logic [CFG_W-1:0]    i_cfg_wr_data;

    t_nbai_out           expected_q[$];
    t_nbai_out           exp_res;
    logic [CFG_W-1:0]    width_reg;
    int                  idle_mode;
    int                  rx_hold;
    int                  n_mismatch;
    int                  n_lost;
    int                  n_checked;
    int                  n_sent;
    int                  n_widths;

    always #2 i_clk = ~i_clk;

    neighbor_block_availability_index_top #(
        .MAX_WIDTH_BLOCKS(MAX_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    // 0: never idle, 1: 0..19 every item, 2: occasional gaps
    function automatic int draw_wait();
        case (idle_mode)
            0: return 0;
            1: return $urandom_range(0, 19);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        endcase
    endfunction

    function automatic int order_cmp(int unsigned ax, int unsigned ay,
                                     int unsigned bx, int unsigned by);
        if (ay < by || (ay == by && ax < bx)) return -1;
        if (ay > by || (ay == by && ax > bx)) return 1;
        return 0;
    endfunction

    // macroblock raster, then 8x8 raster, then 4x4 raster
    function automatic bit decoded_before(int unsigned tx, int unsigned ty,
                                          int unsigned x, int unsigned y);
        int c;
        if (tx == x && ty == y) return 1'b0;
        c = order_cmp(tx / 4, ty / 4, x / 4, y / 4);
        if (c != 0) return c < 0;
        c = order_cmp(tx / 2, ty / 2, x / 2, y / 2);
        if (c != 0) return c < 0;
        return order_cmp(tx, ty, x, y) < 0;
    endfunction

    function automatic t_nbai_out predict_neighbor(t_nbai_in it, logic [CFG_W-1:0] wreg);
        int unsigned w, x, y, pw, tx, ty;
        logic        ok;
        t_nbai_out   r;
        w  = (wreg > MAX_W) ? MAX_W : wreg;
        x  = it.block_x;
        y  = it.block_y;
        pw = it.part_width;
        case (t_kind'(it.neighbor_kind))
            KIND_A: begin
                ok = (x > 0);
                tx = x - 1;
                ty = y;
            end
            KIND_B: begin
                ok = (y > 0);
                tx = x;
                ty = y - 1;
            end
            KIND_C: begin
                tx = x + pw;
                ty = y - 1;
                ok = (tx < w) && (y > 0);
                if (ok) ok = decoded_before(tx, ty, x, y);
            end
            default: begin
                ok = (x > 0) && (y > 0);
                tx = x - 1;
                ty = y - 1;
            end
        endcase
        r.available      = ok;
        r.neighbor_index = ok ? IDX_W'(tx + ty * w) : '0;
        return r;
    endfunction

    function automatic t_nbai_in make_item(int unsigned x, int unsigned y,
                                           int unsigned pw, t_kind kind);
        t_nbai_in it;
        it.block_x       = COORD_W'(x);
        it.block_y       = COORD_W'(y);
        it.part_width    = PW_W'(pw);
        it.neighbor_kind = kind;
        return it;
    endfunction

    // mostly in-frame positions, some at the right edge, some fully random
    function automatic t_nbai_in rand_item();
        t_nbai_in    it;
        int unsigned w;
        int unsigned sel;
        int unsigned k;
        w   = (width_reg > MAX_W) ? MAX_W : width_reg;
        sel = $urandom_range(0, 9);
        k   = $urandom_range(0, 5);
        it.neighbor_kind = (k > 3) ? KIND_C : t_kind'(k);
        it.block_y = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom_range(0, 7))
                                                 : COORD_W'($urandom_range(0, 511));
        if (sel < 6) begin
            it.part_width = PW_W'($urandom_range(1, 4));
            it.block_x    = (w > 0) ? COORD_W'($urandom_range(0, w - 1)) : '0;
        end else if (sel < 8) begin
            it.part_width = PW_W'($urandom_range(1, 4));
            it.block_x    = COORD_W'(int'(w) - int'(it.part_width)
                                     + int'($urandom_range(0, 2)) - 1);
        end else begin
            it.part_width = PW_W'($urandom_range(0, 7));
            it.block_x    = COORD_W'($urandom_range(0, 511));
        end
        return it;
    endfunction

    task automatic send_item(input t_nbai_in it);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_q.insert(expected_q.size(), predict_neighbor(it, width_reg));
        n_sent++;
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (expected_q.size() > 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_q.size() > 0) begin
            $display("ERROR: %0d results never arrived", expected_q.size());
            n_lost++;
            expected_q.delete();
        end
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // only called with the pipeline empty
    task automatic write_width(input logic [CFG_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        width_reg = v;
        n_widths++;
    endtask

    task automatic test_reset_width();
        idle_mode = 2;
        send_item(make_item(0, 5, 1, KIND_A));
        send_item(make_item(5, 0, 1, KIND_B));
        send_item(make_item(3, 0, 1, KIND_D));
        send_item(make_item(3, 3, 1, KIND_D));
        send_item(make_item(475, 4, 4, KIND_C));
        send_item(make_item(476, 4, 4, KIND_C));
        send_item(make_item(0, 0, 1, KIND_C));
        drain_results();
    endtask

    task automatic test_directed_cases();
        idle_mode = 2;
        write_width(10'd512);
        send_item(make_item(511, 511, 4, KIND_A));
        send_item(make_item(511, 511, 4, KIND_B));
        send_item(make_item(511, 511, 4, KIND_C));
        send_item(make_item(511, 511, 4, KIND_D));
        send_item(make_item(0, 1, 1, KIND_C));
        send_item(make_item(1, 1, 1, KIND_C));
        send_item(make_item(2, 2, 1, KIND_C));
        send_item(make_item(3, 1, 1, KIND_C));
        send_item(make_item(3, 4, 1, KIND_C));
        send_item(make_item(4, 8, 0, KIND_C));
        send_item(make_item(500, 9, 7, KIND_C));
        drain_results();
        // zero width: C never available
        write_width(10'd0);
        send_item(make_item(5, 5, 1, KIND_A));
        send_item(make_item(5, 5, 1, KIND_C));
        drain_results();
        // oversized width clamps
        write_width(10'd1023);
        send_item(make_item(508, 4, 3, KIND_C));
        drain_results();
        // width not a multiple of four
        write_width(10'd7);
        send_item(make_item(3, 2, 2, KIND_C));
        drain_results();
    endtask

    task automatic test_random_widths();
        logic [CFG_W-1:0] w_list [N_PHASES];
        int               per_phase;
        w_list[0] = 10'd4;
        w_list[1] = 10'd512;
        w_list[2] = 10'd1023;
        w_list[3] = 10'd0;
        w_list[4] = 10'd7;
        w_list[5] = 10'd516;
        w_list[6] = CFG_W'($urandom_range(1, 128) * 4);
        w_list[7] = CFG_W'($urandom);
        w_list[8] = 10'd480;
        per_phase = RAND_ITEMS / N_PHASES;
        for (int p = 0; p < N_PHASES; p++) begin
            write_width(w_list[p]);
            for (int i = 0; i < per_phase; i++) begin
                if (i % 60 == 0) idle_mode = (i / 60 + p) % 3;
                // sender holds off until the pipeline is empty
                if (i == per_phase / 2 && p % 2 == 0) drain_results();
                send_item(rand_item());
            end
            drain_results();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    if (n_mismatch < 10)
                        $display("ERROR: unexpected result avail=%0b idx=%0d",
                                 o_out_item.available, o_out_item.neighbor_index);
                    n_mismatch++;
                end else begin
                    exp_res = expected_q.pop_front();
                    n_checked++;
                    if (o_out_item.available !== exp_res.available ||
                        o_out_item.neighbor_index !== exp_res.neighbor_index) begin
                        if (n_mismatch < 10)
                            $display("ERROR: result %0d exp avail=%0b idx=%0d got avail=%0b idx=%0d",
                                     n_checked, exp_res.available, exp_res.neighbor_index,
                                     o_out_item.available, o_out_item.neighbor_index);
                        n_mismatch++;
                    end
                end
                rx_hold = draw_wait();
            end
            i_out_stall <= (rx_hold > 0);
            if (rx_hold > 0) rx_hold--;
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_item     <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        width_reg  = 10'd480;
        idle_mode  = 0;
        n_lost     = 0;
        n_sent     = 0;
        n_widths   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_width();
        test_directed_cases();
        test_random_widths();
        drain_results();

        $display("Sent %0d lookups, checked %0d results across %0d frame widths written",
                 n_sent, n_checked, n_widths);
        $display("All four neighbor kinds, zero, odd and oversized widths, with random stalls");
        if (n_mismatch == 0 && n_lost == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
